// ----- rtl/assert_macros.svh -----
// assertion macros for the checker rtl
// depends on nothing; taken in by `include inside module bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge, held off while reset is asserted
`define CNLC_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked with the next cycle
`define CNLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cnlc_pkg.sv -----
// shared types, constants and helper functions for the card number checker
// depends on nothing
package cnlc_pkg;

	localparam int unsigned MAX_DIGIT_LIMIT = 19;
	localparam int unsigned CNT_W = 5;
	localparam int unsigned LEAD_W = 10;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 10;

	typedef logic [CNT_W-1:0] count_t;
	typedef logic [3:0] digit_t;
	typedef logic [1:0] status_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam count_t COUNT_SAT = 5'd31;
	localparam count_t DIGIT_LIMIT = CNT_W'(MAX_DIGIT_LIMIT);

	localparam status_t ST_OK = 2'd0;
	localparam status_t ST_BAD_LENGTH = 2'd1;
	localparam status_t ST_BAD_LEADING = 2'd2;
	localparam status_t ST_BAD_CHECK = 2'd3;

	localparam cfg_idx_t REG_MIN_DIGITS = 2'd0;
	localparam cfg_idx_t REG_MAX_DIGITS = 2'd1;
	localparam cfg_idx_t REG_ALLOWED_LEADING = 2'd2;

	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;

	typedef struct packed {
		count_t min_digits;
		count_t max_digits;
		logic [LEAD_W-1:0] allowed_leading;
	} cfg_t;

	function automatic digit_t add_mod10(input digit_t s, input digit_t v);
		logic [4:0] t;
		t = {1'b0, s} + {1'b0, v};
		return (t >= 5'd10) ? digit_t'(t - 5'd10) : t[3:0];
	endfunction

	function automatic digit_t doubled(input digit_t d);
		logic [4:0] t;
		t = {d, 1'b0};
		return (t >= 5'd10) ? digit_t'(t - 5'd9) : t[3:0];
	endfunction

endpackage

// ----- rtl/cnlc_cfg_regs.sv -----
// configuration registers: digit bounds and allowed leading digits
// depends on cnlc_pkg
module cnlc_cfg_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  cnlc_pkg::cfg_idx_t        wr_index,
	input  logic [cnlc_pkg::CFG_DATA_W-1:0] wr_data,
	output cnlc_pkg::cfg_t            cfg
);
	import cnlc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_digits <= 5'd13;
			cfg_q.max_digits <= 5'd16;
			cfg_q.allowed_leading <= 10'd48;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MIN_DIGITS:      cfg_q.min_digits <= wr_data[CNT_W-1:0];
				REG_MAX_DIGITS:      cfg_q.max_digits <= wr_data[CNT_W-1:0];
				REG_ALLOWED_LEADING: cfg_q.allowed_leading <= wr_data[LEAD_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/cnlc_core.sv -----
// input register, running luhn sums and result register
// depends on cnlc_pkg and assert_macros.svh
module cnlc_core (
	input  logic               clk,
	input  logic               arst_n,
	input  cnlc_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         char_code,
	input  logic               is_last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               valid_res,
	output cnlc_pkg::status_t  status,
	output cnlc_pkg::count_t   digit_total
);
	import cnlc_pkg::*;
	`include "assert_macros.svh"

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	count_t  digit_count_q;
	digit_t  leading_q;
	digit_t  sum_even_q;
	digit_t  sum_odd_q;

	logic    out_valid_q;
	logic    valid_res_q;
	status_t status_q;
	count_t  total_q;

	logic    advance;
	logic    take;
	digit_t  d;
	count_t  cnt_nxt;
	digit_t  lead_nxt;
	digit_t  even_nxt;
	digit_t  odd_nxt;
	digit_t  sum_sel;
	status_t st_nxt;

	assign advance  = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			char_s1 <= char_code;
			last_s1 <= is_last;
		end
	end

	// digit update
	always_comb begin
		take = (char_s1 >= CHAR_ZERO) && (char_s1 <= CHAR_NINE) && (digit_count_q != COUNT_SAT);
		d = char_s1[3:0];
		cnt_nxt = digit_count_q;
		lead_nxt = leading_q;
		even_nxt = sum_even_q;
		odd_nxt = sum_odd_q;
		if (take) begin
			cnt_nxt = digit_count_q + 5'd1;
			if (digit_count_q == '0) begin
				lead_nxt = d;
			end
			if (!digit_count_q[0]) begin
				even_nxt = add_mod10(sum_even_q, doubled(d));
				odd_nxt = add_mod10(sum_odd_q, d);
			end else begin
				even_nxt = add_mod10(sum_even_q, d);
				odd_nxt = add_mod10(sum_odd_q, doubled(d));
			end
		end
	end

	// first failing check wins
	always_comb begin
		sum_sel = cnt_nxt[0] ? odd_nxt : even_nxt;
		if (cnt_nxt == '0 || cnt_nxt == COUNT_SAT || cnt_nxt < cfg.min_digits ||
			cnt_nxt > cfg.max_digits || cnt_nxt > DIGIT_LIMIT) begin
			st_nxt = ST_BAD_LENGTH;
		end else if (!cfg.allowed_leading[lead_nxt]) begin
			st_nxt = ST_BAD_LEADING;
		end else if (sum_sel != '0) begin
			st_nxt = ST_BAD_CHECK;
		end else begin
			st_nxt = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_count_q <= '0;
			leading_q <= '0;
			sum_even_q <= '0;
			sum_odd_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				digit_count_q <= '0;
				leading_q <= '0;
				sum_even_q <= '0;
				sum_odd_q <= '0;
			end else begin
				digit_count_q <= cnt_nxt;
				leading_q <= lead_nxt;
				sum_even_q <= even_nxt;
				sum_odd_q <= odd_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			valid_res_q <= (st_nxt == ST_OK);
			status_q <= st_nxt;
			total_q <= cnt_nxt;
		end
	end

	assign out_valid   = out_valid_q;
	assign valid_res   = valid_res_q;
	assign status      = status_q;
	assign digit_total = total_q;

	`CNLC_ASSERT(a_res_flag, clk, arst_n, !out_valid_q || (valid_res_q == (status_q == ST_OK)), "result flag disagrees with status")
	`CNLC_ASSERT(a_sums_mod10, clk, arst_n, (sum_even_q < 4'd10) && (sum_odd_q < 4'd10), "running sum out of range")
	`CNLC_ASSERT_NEXT(a_clear_after_word, clk, arst_n, advance && last_s1, digit_count_q == '0 && out_valid_q, "state not cleared after final word")
	`CNLC_ASSERT(a_ok_length, clk, arst_n, !(out_valid_q && status_q == ST_OK) || (total_q != '0 && total_q <= DIGIT_LIMIT), "ok result with impossible length")

endmodule

// ----- rtl/card_number_luhn_checker_top.sv -----
// top level of the streaming card number luhn checker
// depends on cnlc_pkg, cnlc_cfg_regs and cnlc_core
//
//  channel  | handshake              | fields
//  ---------+------------------------+-----------------------------------
//  in       | in_valid / in_ready    | char_code, is_last
//  out      | out_valid / out_ready  | valid_res, status, digit_total
//  cfg      | wr_en (no wait)        | wr_index, wr_data
//
// one word per cycle sustained, but a final word stalls in the input register while an earlier
// result waits unaccepted; a final word's result is then captured in the result register
// in_ready depends combinationally on out_ready only when the word held is a final one
// while a result waits, non-final words keep flowing through the sums
// reset clears handshake state, sums and count and loads register defaults
module card_number_luhn_checker_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                char_code,
	input  logic                      is_last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      valid_res,
	output logic [1:0]                status,
	output logic [4:0]                digit_total,
	input  logic                      wr_en,
	input  logic [1:0]                wr_index,
	input  logic [cnlc_pkg::CFG_DATA_W-1:0] wr_data
);
	import cnlc_pkg::*;

	cfg_t cfg;

	cnlc_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	cnlc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.char_code   (char_code),
		.is_last     (is_last),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.valid_res   (valid_res),
		.status      (status),
		.digit_total (digit_total)
	);

endmodule
